// ===== src/grle_pkg.sv =====
// Shared types and constants for the grouped run-length encoder.
// Used by the front, queue and back modules and by the top level; no dependencies.
package grle_pkg;

  // A run is closed and restarted once it holds this many bytes.
  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Token slots of one queue entry, in emission order.
  localparam int NSLOTS = 6;
  localparam logic [2:0] SLOT_PEND_SYM  = 3'd0;
  localparam logic [2:0] SLOT_PEND_CNT  = 3'd1;
  localparam logic [2:0] SLOT_FLUSH_SYM = 3'd2;
  localparam logic [2:0] SLOT_FLUSH_CNT = 3'd3;
  localparam logic [2:0] SLOT_LAST_SYM  = 3'd4;
  localparam logic [2:0] SLOT_LAST_CNT  = 3'd5;

  typedef enum logic {
    KIND_SYMBOL = 1'b0,
    KIND_COUNT  = 1'b1
  } tok_kind_t;

  // Up to six tokens caused by one input byte; mask bit i marks slot i present.
  typedef struct packed {
    logic [NSLOTS-1:0] mask;
    logic [7:0]        pend_sym;
    logic [15:0]       pend_len;
    logic [7:0]        flush_sym;
    logic [15:0]       flush_len;
    logic [7:0]        last_sym;
    logic [15:0]       last_len;
  } grle_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } grle_q_status_t;

endpackage

// ===== src/grouped_run_length_encoder.sv =====
// Top level of the grouped run-length encoder.
// Instantiates grle_front, grle_fifo and grle_back; depends on grle_pkg.
//
// The encoder takes one byte per word and emits typed tokens: a symbol token
// (out_tuser 0, byte in the low eight bits of out_tdata) or a count token
// (out_tuser 1, run length in out_tdata). Each closed run is held back until
// the run after it closes; consecutive runs of equal length share one count
// token that follows the last symbol of the group. A run that reaches 65535
// bytes is closed and a new run of the same symbol starts. The word carrying
// in_tlast ends the string: all remaining runs are flushed, the last count
// token carries out_tlast, and the next byte starts a fresh string. Bytes are
// taken at one per cycle as long as the four-entry token queue has room; a
// byte that extends a run and does not end the string produces no tokens and
// never occupies the queue. Tokens leave at one per cycle while out_tready is
// high; a run boundary yields up to two tokens and a final byte up to six. The
// queue lets the input keep flowing while those drain, and the output register
// lets a new byte enter while a finished token still waits for out_tready.
module grouped_run_length_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // is_final
  // Output tokens.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] token_value
  output logic        out_tuser,  // [0] token_kind
  output logic        out_tlast   // end_of_output
);
  import grle_pkg::*;

  grle_entry_t    push_entry;
  grle_entry_t    head;
  grle_q_status_t q_status;
  logic           push_valid;
  logic           pop;

  // Front: run tracking and token planning, one byte per cycle while the queue has room.
  grle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // Queue of planned token groups.
  grle_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back: token serializer and output register.
  grle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/grle_front.sv =====
// Front part of the grouped run-length encoder: takes bytes, tracks the current
// and pending runs, and turns each byte that yields tokens into one queue entry.
// Depends on grle_pkg.
module grle_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,
  input  logic                     in_tlast,
  input  grle_pkg::grle_q_status_t q_status,
  output logic                     push_valid,
  output grle_pkg::grle_entry_t    push_entry
);
  import grle_pkg::*;

  logic        run_active_r, run_active_nxt;
  logic [7:0]  run_symbol_r, run_symbol_nxt;
  logic [15:0] run_length_r, run_length_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_symbol_r, pend_symbol_nxt;
  logic [15:0] pend_length_r, pend_length_nxt;

  logic        accept;
  logic        extend;
  logic        p_v1;
  logic [7:0]  p_sym1;
  logic [15:0] p_len1;
  logic [7:0]  r_sym1;
  logic [15:0] r_len1;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    extend = run_active_r && (in_tdata == run_symbol_r) && (run_length_r < RUN_MAX);

    // Effect of the byte itself: extend the run, or close it and start anew.
    p_v1   = pend_valid_r;
    p_sym1 = pend_symbol_r;
    p_len1 = pend_length_r;
    if (extend) begin
      r_sym1 = run_symbol_r;
      r_len1 = run_length_r + 16'd1;
    end else begin
      r_sym1 = in_tdata;
      r_len1 = 16'd1;
      if (run_active_r) begin
        p_v1   = 1'b1;
        p_sym1 = run_symbol_r;
        p_len1 = run_length_r;
      end
    end

    push_entry                      = '0;
    push_entry.pend_sym             = pend_symbol_r;
    push_entry.pend_len             = pend_length_r;
    push_entry.mask[SLOT_PEND_SYM]  = run_active_r && !extend && pend_valid_r;
    push_entry.mask[SLOT_PEND_CNT]  = run_active_r && !extend && pend_valid_r &&
                                      (pend_length_r != run_length_r);
    // Final byte: flush the pending run, then the run the byte belongs to.
    push_entry.flush_sym            = p_sym1;
    push_entry.flush_len            = p_len1;
    push_entry.mask[SLOT_FLUSH_SYM] = in_tlast && p_v1;
    push_entry.mask[SLOT_FLUSH_CNT] = in_tlast && p_v1 && (p_len1 != r_len1);
    push_entry.last_sym             = r_sym1;
    push_entry.last_len             = r_len1;
    push_entry.mask[SLOT_LAST_SYM]  = in_tlast;
    push_entry.mask[SLOT_LAST_CNT]  = in_tlast;

    push_valid = accept && (|push_entry.mask);

    if (in_tlast) begin
      run_active_nxt  = 1'b0;
      run_symbol_nxt  = '0;
      run_length_nxt  = '0;
      pend_valid_nxt  = 1'b0;
      pend_symbol_nxt = '0;
      pend_length_nxt = '0;
    end else begin
      run_active_nxt  = 1'b1;
      run_symbol_nxt  = r_sym1;
      run_length_nxt  = r_len1;
      pend_valid_nxt  = p_v1;
      pend_symbol_nxt = p_sym1;
      pend_length_nxt = p_len1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r  <= 1'b0;
      run_symbol_r  <= '0;
      run_length_r  <= '0;
      pend_valid_r  <= 1'b0;
      pend_symbol_r <= '0;
      pend_length_r <= '0;
    end else if (accept) begin
      run_active_r  <= run_active_nxt;
      run_symbol_r  <= run_symbol_nxt;
      run_length_r  <= run_length_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_symbol_r <= pend_symbol_nxt;
      pend_length_r <= pend_length_nxt;
    end
  end

endmodule

// ===== src/grle_fifo.sv =====
// Short entry queue between the front and back parts of the encoder.
// Depends on grle_pkg.
module grle_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  input  grle_pkg::grle_entry_t    push_entry,
  input  logic                     pop,
  output grle_pkg::grle_entry_t    head,
  output grle_pkg::grle_q_status_t status
);
  import grle_pkg::*;

  grle_entry_t    slots_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign head         = slots_r[rd_ptr_r];
  assign status.full  = (count_r == (QAW+1)'(QDEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push_valid) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== src/grle_back.sv =====
// Back part of the encoder: walks the token slots of the head queue entry and
// sends one token per cycle, as out_tready allows, through a registered output stage.
// Depends on grle_pkg.
module grle_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  grle_pkg::grle_entry_t    head,
  input  grle_pkg::grle_q_status_t q_status,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);
  import grle_pkg::*;

  logic [NSLOTS-1:0] done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r;
  tok_kind_t         out_kind_r;
  logic              out_last_r;

  logic [NSLOTS-1:0] remain;
  logic [NSLOTS-1:0] pick;
  logic [2:0]        sel;
  logic              found;
  logic              load;
  logic              last_tok;
  logic [15:0]       tok_value;
  tok_kind_t         tok_kind;

  always_comb begin
    remain = q_status.empty ? '0 : (head.mask & ~done_r);
    pick   = '0;
    sel    = SLOT_PEND_SYM;
    found  = 1'b0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (remain[i] && !found) begin
        found   = 1'b1;
        pick[i] = 1'b1;
        sel     = 3'(i);
      end
    end

    load     = found && (!out_valid_r || out_tready);
    last_tok = ((remain & ~pick) == '0);
    pop      = load && last_tok;

    if (pop) begin
      done_nxt = '0;
    end else if (load) begin
      done_nxt = done_r | pick;
    end else begin
      done_nxt = done_r;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    case (sel)
      SLOT_PEND_SYM: begin
        tok_kind  = KIND_SYMBOL;
        tok_value = {8'd0, head.pend_sym};
      end
      SLOT_PEND_CNT: begin
        tok_kind  = KIND_COUNT;
        tok_value = head.pend_len;
      end
      SLOT_FLUSH_SYM: begin
        tok_kind  = KIND_SYMBOL;
        tok_value = {8'd0, head.flush_sym};
      end
      SLOT_FLUSH_CNT: begin
        tok_kind  = KIND_COUNT;
        tok_value = head.flush_len;
      end
      SLOT_LAST_SYM: begin
        tok_kind  = KIND_SYMBOL;
        tok_value = {8'd0, head.last_sym};
      end
      SLOT_LAST_CNT: begin
        tok_kind  = KIND_COUNT;
        tok_value = head.last_len;
      end
      default: begin
        tok_kind  = KIND_SYMBOL;
        tok_value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= tok_value;
      out_kind_r <= tok_kind;
      out_last_r <= (sel == SLOT_LAST_CNT);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/grle_checker.sv =====
// Port-level checks for the grouped run-length encoder, bound to the top level.
// Depends only on the top-level ports.
module grle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled token holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output token changed while stalled");

  // Symbol tokens carry a byte only.
  a_sym_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:8] == 8'd0)
    else $error("symbol token wider than a byte");

  // The end of a string is always marked on a count token.
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end mark on a symbol token");

  // A run always holds at least one byte.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata != 16'd0)
    else $error("zero run length");

endmodule

bind grouped_run_length_encoder grle_checker u_grle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
